// ===== rtl/cbf_pkg.sv =====
// cbf_pkg: widths, constants and word types shared by the cubic b-spline
// fetch offset block. No dependencies; compiled before every other file.
package cbf_pkg;

  // field widths
  localparam int COORD_W = 17;
  localparam int RES_W   = 11;
  localparam int FRAC_W  = 16;
  localparam int POS_W   = 19;
  localparam int WGT_W   = 18;

  // resolution clamp default
  localparam int MAX_RES_DEF = 1024;

  // cell index: cell < 2*res with res below 2^RES_W
  localparam int CELL_W = RES_W + 2;

  // ratio numerators and denominators (weights times 6, Q.48)
  localparam int RAT_W    = 51;
  localparam int RAT_FRAC = 32;
  localparam int RAT_Q_W  = RAT_FRAC + 1;

  // fetch position in Q.32 texel units, signed
  localparam int PLACE_W = 47;

  // position divide: quotient carries one extra bit for rounding
  localparam int POS_Q_W = POS_W;
  localparam int POS_N_W = RES_W + POS_Q_W;

  // blend weight: divide by three through a reciprocal
  localparam int Y_W        = 18;
  localparam int RECIP3_W   = 19;
  localparam int RECIP3     = 349526;
  localparam int RECIP3_SH  = 20;
  localparam int GM_W       = 17;

  localparam int HALF_Q16 = 32768;
  localparam int ONE_Q16  = 65536;
  localparam int POS_LIM  = 131072;
  localparam int WGT_LIM  = 65536;

  // op codes
  localparam logic OP_VALUE = 1'b0;
  localparam logic OP_DERIV = 1'b1;

  // cell and blend weight that ride along with the ratio divide
  typedef struct packed {
    logic signed [CELL_W-1:0] texel_idx;
    logic signed [WGT_W-1:0]  g;
  } side_t;

  // ratio divide job out of the weight pipeline
  typedef struct packed {
    logic [RAT_W-1:0] n0;
    logic [RAT_W-1:0] d0;
    logic [RAT_W-1:0] n1;
    logic [RAT_W-1:0] d1;
    side_t            side;
  } job_t;

  // signs and blend weight that ride along with the position divide
  typedef struct packed {
    logic                    neg0;
    logic                    neg1;
    logic signed [WGT_W-1:0] g;
  } place_t;

endpackage

// ===== rtl/cbf_if.sv =====
// cbf_if: valid/ready channel interfaces for the coordinate word and the
// offset word. Depends on cbf_pkg.
interface cbf_in_if;
  import cbf_pkg::*;
  logic               valid;
  logic               ready;
  logic               op;
  logic [COORD_W-1:0] coord;

  modport source (output valid, op, coord, input ready);
  modport sink (input valid, op, coord, output ready);
endinterface

interface cbf_out_if;
  import cbf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] near_fetch_pos;
  logic signed [POS_W-1:0] far_fetch_pos;
  logic signed [WGT_W-1:0] first_pair_weight;

  modport source (output valid, near_fetch_pos, far_fetch_pos, first_pair_weight,
                  input ready);
  modport sink (input valid, near_fetch_pos, far_fetch_pos, first_pair_weight,
                output ready);
endinterface

// ===== rtl/cbf_div_pipe.sv =====
// cbf_div_pipe: pipelined restoring divider, one quotient bit per stage,
// several lanes in lockstep plus a sideband. Standalone, no package use.
module cbf_div_pipe #(
  parameter int LANES = 2,
  parameter int DEN_W = 8,
  parameter int QUO_W = 8,
  parameter int SB_W  = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [DEN_W+QUO_W-1:0] in_num [LANES],
  input  logic [DEN_W-1:0]       in_den [LANES],
  input  logic [SB_W-1:0]        in_sb,
  output logic                   out_valid,
  output logic [QUO_W-1:0]       out_quo [LANES],
  output logic [SB_W-1:0]        out_sb
);

  // top DEN_W bits of the numerator must be below the divisor
  logic [QUO_W-1:0] vld_r;
  logic [DEN_W-1:0] rem_r   [QUO_W][LANES];
  logic [DEN_W-1:0] den_r   [QUO_W][LANES];
  logic [QUO_W-1:0] qr_r    [QUO_W][LANES];
  logic [DEN_W-1:0] rem_nxt [QUO_W][LANES];
  logic [QUO_W-1:0] qr_nxt  [QUO_W][LANES];
  logic [DEN_W-1:0] rem_src [QUO_W][LANES];
  logic [DEN_W-1:0] den_src [QUO_W][LANES];
  logic [QUO_W-1:0] qr_src  [QUO_W][LANES];
  logic [SB_W-1:0]  sb_r    [QUO_W];

  // stage inputs: the entry word for the first stage, else the stage before
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_src[0][l] = in_num[l][DEN_W+QUO_W-1:QUO_W];
      qr_src[0][l]  = in_num[l][QUO_W-1:0];
      den_src[0][l] = in_den[l];
    end
    for (int s = 1; s < QUO_W; s++) begin
      for (int l = 0; l < LANES; l++) begin
        rem_src[s][l] = rem_r[s-1][l];
        qr_src[s][l]  = qr_r[s-1][l];
        den_src[s][l] = den_r[s-1][l];
      end
    end
  end

  // one compare-subtract per stage; quotient bits shift in from the bottom
  always_comb begin
    logic [DEN_W:0] trial;
    for (int s = 0; s < QUO_W; s++) begin
      for (int l = 0; l < LANES; l++) begin
        trial = {rem_src[s][l], qr_src[s][l][QUO_W-1]};
        if (trial >= {1'b0, den_src[s][l]}) begin
          rem_nxt[s][l] = DEN_W'(trial - {1'b0, den_src[s][l]});
          qr_nxt[s][l]  = {qr_src[s][l][QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[s][l] = trial[DEN_W-1:0];
          qr_nxt[s][l]  = {qr_src[s][l][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QUO_W-2:0], in_valid};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= in_sb;
      for (int s = 1; s < QUO_W; s++) begin
        sb_r[s] <= sb_r[s-1];
      end
      for (int s = 0; s < QUO_W; s++) begin
        for (int l = 0; l < LANES; l++) begin
          rem_r[s][l] <= rem_nxt[s][l];
          qr_r[s][l]  <= qr_nxt[s][l];
          den_r[s][l] <= den_src[s][l];
        end
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_sb    = sb_r[QUO_W-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_quo[l] = qr_r[QUO_W-1][l];
    end
  end

endmodule

// ===== rtl/cbf_weights.sv =====
// cbf_weights: seven-stage pipeline from coordinate to cell, fraction,
// kernel weight ratios (numerators, denominators) and blend weight.
// Depends on cbf_pkg.
module cbf_weights (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic                        in_op,
  input  logic [cbf_pkg::COORD_W-1:0] in_coord,
  input  logic [cbf_pkg::RES_W-1:0]   res,
  output logic                        out_valid,
  output cbf_pkg::job_t               out_job
);
  import cbf_pkg::*;

  localparam int PROD_W  = COORD_W + RES_W;
  localparam int X_W     = PROD_W + 1;
  localparam int B_W     = FRAC_W + 1;
  localparam int SQ_W    = 2 * FRAC_W;
  localparam int CUBE_W  = 3 * FRAC_W;
  localparam int BSQ_W   = 2 * FRAC_W + 1;
  localparam int BCUBE_W = 3 * FRAC_W + 1;
  localparam int TERM_W  = RAT_W + 1;
  localparam int RP_W    = Y_W + RECIP3_W;

  logic [6:0] vld_r;

  // stage 1: scaled coordinate, cell and fraction
  logic [PROD_W-1:0]        prod1;
  logic signed [X_W-1:0]    x1;
  logic                     op1_r;
  logic signed [CELL_W-1:0] cell1_r;
  logic [FRAC_W-1:0]        a1_r;

  assign prod1 = PROD_W'(in_coord) * PROD_W'(res);
  assign x1    = $signed({1'b0, prod1}) - $signed(X_W'(HALF_Q16));

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= in_op;
      cell1_r <= x1[X_W-1:FRAC_W];
      a1_r    <= x1[FRAC_W-1:0];
    end
  end

  // stage 2: a squared and b = 1 - a
  logic                     op2_r;
  logic signed [CELL_W-1:0] cell2_r;
  logic [FRAC_W-1:0]        a2_r;
  logic [SQ_W-1:0]          sq2_r;
  logic [B_W-1:0]           b2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r   <= op1_r;
      cell2_r <= cell1_r;
      a2_r    <= a1_r;
      sq2_r   <= SQ_W'(a1_r) * SQ_W'(a1_r);
      b2_r    <= B_W'(ONE_Q16) - {1'b0, a1_r};
    end
  end

  // stage 3: a cubed and b squared
  logic [CUBE_W-1:0]        cube_full3;
  logic [2*B_W-1:0]         bsq_full3;
  logic                     op3_r;
  logic signed [CELL_W-1:0] cell3_r;
  logic [FRAC_W-1:0]        a3_r;
  logic [SQ_W-1:0]          sq3_r;
  logic [CUBE_W-1:0]        cube3_r;
  logic [B_W-1:0]           b3_r;
  logic [BSQ_W-1:0]         bsq3_r;

  assign cube_full3 = CUBE_W'(sq2_r) * CUBE_W'(a2_r);
  assign bsq_full3  = (2*B_W)'(b2_r) * (2*B_W)'(b2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      op3_r   <= op2_r;
      cell3_r <= cell2_r;
      a3_r    <= a2_r;
      sq3_r   <= sq2_r;
      cube3_r <= cube_full3;
      b3_r    <= b2_r;
      bsq3_r  <= bsq_full3[BSQ_W-1:0];
    end
  end

  // stage 4: b cubed and the polynomial terms of both kernels
  logic [BSQ_W+B_W-1:0]     bcube_full4;
  logic [TERM_W-1:0]        w1v4, d1v4, n0d4, dd4;
  logic                     op4_r;
  logic signed [CELL_W-1:0] cell4_r;
  logic [SQ_W-1:0]          sq4_r;
  logic [CUBE_W-1:0]        cube4_r;
  logic [BCUBE_W-1:0]       bcube4_r;
  logic [RAT_W-1:0]         w1v4_r, d1v4_r, n0d4_r, dd4_r;

  assign bcube_full4 = (BSQ_W+B_W)'(bsq3_r) * (BSQ_W+B_W)'(b3_r);
  // value kernel: 6*w1 and 6*(w2 + w3), Q.48
  assign w1v4 = TERM_W'(cube3_r) * TERM_W'(3) + (TERM_W'(1) << 50)
              - ((TERM_W'(sq3_r) * TERM_W'(6)) << 16);
  assign d1v4 = ((TERM_W'(sq3_r) * TERM_W'(3)) << 16) + ((TERM_W'(a3_r) * TERM_W'(3)) << 32)
              + (TERM_W'(1) << 48) - (TERM_W'(cube3_r) << 1);
  // derivative kernel with the common factor 3*2^16 taken out
  assign n0d4 = (TERM_W'(a3_r) << 18) - TERM_W'(sq3_r) * TERM_W'(3);
  assign dd4  = (TERM_W'(1) << 32) + (TERM_W'(a3_r) << 17) - (TERM_W'(sq3_r) << 1);

  always_ff @(posedge clk) begin
    if (en) begin
      op4_r    <= op3_r;
      cell4_r  <= cell3_r;
      sq4_r    <= sq3_r;
      cube4_r  <= cube3_r;
      bcube4_r <= bcube_full4[BCUBE_W-1:0];
      w1v4_r   <= w1v4[RAT_W-1:0];
      d1v4_r   <= d1v4[RAT_W-1:0];
      n0d4_r   <= n0d4[RAT_W-1:0];
      dd4_r    <= dd4[RAT_W-1:0];
    end
  end

  // stage 5: pick ratio operands and the first pair magnitude by mode
  logic [RAT_W-1:0]         d0v5;
  logic [RAT_W-1:0]         n0_5, d0_5, n1_5, d1_5, m5;
  logic                     neg5_r;
  logic signed [CELL_W-1:0] cell5_r;
  logic [RAT_W-1:0]         n0_5_r, d0_5_r, n1_5_r, d1_5_r, m5_r;

  assign d0v5 = RAT_W'(bcube4_r) + w1v4_r;

  always_comb begin
    if (op4_r == OP_DERIV) begin
      n0_5 = n0d4_r;
      d0_5 = dd4_r;
      n1_5 = RAT_W'(sq4_r);
      d1_5 = dd4_r;
      m5   = (dd4_r << 17) + (dd4_r << 16);
    end else begin
      n0_5 = w1v4_r;
      d0_5 = d0v5;
      n1_5 = RAT_W'(cube4_r);
      d1_5 = d1v4_r;
      m5   = d0v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg5_r  <= (op4_r == OP_DERIV);
      cell5_r <= cell4_r;
      n0_5_r  <= n0_5;
      d0_5_r  <= d0_5;
      n1_5_r  <= n1_5;
      d1_5_r  <= d1_5;
      m5_r    <= m5;
    end
  end

  // stage 6: round the first pair sum to units of 2^-16 times three
  logic [TERM_W-1:0]        ysum6;
  logic                     neg6_r;
  logic signed [CELL_W-1:0] cell6_r;
  logic [RAT_W-1:0]         n0_6_r, d0_6_r, n1_6_r, d1_6_r;
  logic [Y_W-1:0]           y6_r;

  assign ysum6 = TERM_W'(m5_r) + (TERM_W'(3) << 32);

  always_ff @(posedge clk) begin
    if (en) begin
      neg6_r  <= neg5_r;
      cell6_r <= cell5_r;
      n0_6_r  <= n0_5_r;
      d0_6_r  <= d0_5_r;
      n1_6_r  <= n1_5_r;
      d1_6_r  <= d1_5_r;
      y6_r    <= ysum6[Y_W+32:33];
    end
  end

  // stage 7: divide by three, clamp, apply sign
  logic [RP_W-1:0]          rp7;
  logic [GM_W-1:0]          gm7, gs7;
  logic signed [WGT_W-1:0]  g7;

  assign rp7 = RP_W'(y6_r) * RP_W'(RECIP3);
  assign gm7 = rp7[RECIP3_SH+GM_W-1:RECIP3_SH];
  assign gs7 = (gm7 > GM_W'(WGT_LIM)) ? GM_W'(WGT_LIM) : gm7;
  assign g7  = neg6_r ? -$signed(WGT_W'(gs7)) : $signed(WGT_W'(gs7));

  always_ff @(posedge clk) begin
    if (en) begin
      out_job.n0             <= n0_6_r;
      out_job.d0             <= d0_6_r;
      out_job.n1             <= n1_6_r;
      out_job.d1             <= d1_6_r;
      out_job.side.texel_idx <= cell6_r;
      out_job.side.g         <= g7;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  assign out_valid = vld_r[6];

endmodule

// ===== rtl/cbf_pos_prep.sv =====
// cbf_pos_prep: one stage that rounds the two ratios and forms the signed
// texel positions, handing magnitudes to the position divide. Depends on cbf_pkg.
module cbf_pos_prep (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [cbf_pkg::RAT_Q_W-1:0] in_q0,
  input  logic [cbf_pkg::RAT_Q_W-1:0] in_q1,
  input  cbf_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [cbf_pkg::POS_N_W-1:0] out_n0,
  output logic [cbf_pkg::POS_N_W-1:0] out_n1,
  output cbf_pkg::place_t             out_place
);
  import cbf_pkg::*;

  localparam int SH = FRAC_W - 1;

  logic                      vld_r;
  logic [RAT_Q_W:0]          sum0, sum1;
  logic [RAT_Q_W-1:0]        r0, r1;
  logic signed [PLACE_W-1:0] cellx, p0, p1;
  logic [PLACE_W-1:0]        mag0, mag1;

  // ratios rounded to 32 fractional bits
  assign sum0 = {1'b0, in_q0} + (RAT_Q_W+1)'(1);
  assign sum1 = {1'b0, in_q1} + (RAT_Q_W+1)'(1);
  assign r0   = sum0[RAT_Q_W:1];
  assign r1   = sum1[RAT_Q_W:1];

  // tc - 0.5 + r0 and tc + 1.5 + r1 in Q.32 texels
  assign cellx = PLACE_W'($signed(in_side.texel_idx)) <<< 1;
  assign p0 = ((cellx - $signed(PLACE_W'(1))) <<< (RAT_FRAC - 1)) + $signed(PLACE_W'(r0));
  assign p1 = ((cellx + $signed(PLACE_W'(3))) <<< (RAT_FRAC - 1)) + $signed(PLACE_W'(r1));

  assign mag0 = p0[PLACE_W-1] ? PLACE_W'(-p0) : PLACE_W'(p0);
  assign mag1 = p1[PLACE_W-1] ? PLACE_W'(-p1) : PLACE_W'(p1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_n0         <= mag0[SH+POS_N_W-1:SH];
      out_n1         <= mag1[SH+POS_N_W-1:SH];
      out_place.neg0 <= p0[PLACE_W-1];
      out_place.neg1 <= p1[PLACE_W-1];
      out_place.g    <= in_side.g;
    end
  end

  assign out_valid = vld_r;

endmodule

// ===== rtl/cubic_bspline_fetch_offsets.sv =====
// cubic_bspline_fetch_offsets: top level of the cubic b-spline fetch offset
// block. Depends on cbf_pkg, cbf_if, cbf_weights, cbf_div_pipe, cbf_pos_prep.
//
// Takes one coordinate word per clock while the output side is not stalled
// and returns one offset word per word, in order, through the weight
// pipeline, the ratio divide (one quotient bit per stage), position
// assembly, the divide by the grid resolution and the output register.
// Every stage advances together; when the output word waits, the whole
// pipeline holds and in_chan.ready drops. The resolution
// register is written through cfg_wr_en/cfg_wr_data and must only change while
// no word is in flight; zero acts as one and values above MAX_RES as MAX_RES.
module cubic_bspline_fetch_offsets #(
  parameter int MAX_RES = cbf_pkg::MAX_RES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [cbf_pkg::RES_W-1:0] cfg_wr_data,
  cbf_in_if.sink                    in_chan,
  cbf_out_if.source                 out_chan
);
  import cbf_pkg::*;

  logic             en;
  logic [RES_W-1:0] cfg_res_r;
  logic [RES_W-1:0] res_eff;

  // resolution register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_res_r <= RES_W'(64);
    end else if (cfg_wr_en) begin
      cfg_res_r <= cfg_wr_data;
    end
  end

  // clamp into the supported range
  always_comb begin
    if (cfg_res_r == '0) begin
      res_eff = RES_W'(1);
    end else if (int'(cfg_res_r) > MAX_RES) begin
      res_eff = RES_W'(MAX_RES);
    end else begin
      res_eff = cfg_res_r;
    end
  end

  // global advance: hold everything while the output word waits
  logic out_valid_r;
  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // weights
  logic  wt_valid;
  job_t  wt_job;

  cbf_weights u_weights (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_chan.valid),
    .in_op     (in_chan.op),
    .in_coord  (in_chan.coord),
    .res       (res_eff),
    .out_valid (wt_valid),
    .out_job   (wt_job)
  );

  // ratio divide, both pairs
  logic [RAT_W+RAT_Q_W-1:0] rat_num [2];
  logic [RAT_W-1:0]         rat_den [2];
  logic [RAT_Q_W-1:0]       rat_quo [2];
  logic                     rat_valid;
  side_t                    rat_side;

  assign rat_num[0] = {wt_job.n0, {RAT_Q_W{1'b0}}};
  assign rat_num[1] = {wt_job.n1, {RAT_Q_W{1'b0}}};
  assign rat_den[0] = wt_job.d0;
  assign rat_den[1] = wt_job.d1;

  cbf_div_pipe #(
    .LANES (2),
    .DEN_W (RAT_W),
    .QUO_W (RAT_Q_W),
    .SB_W  ($bits(side_t))
  ) u_ratio_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (wt_valid),
    .in_num    (rat_num),
    .in_den    (rat_den),
    .in_sb     (wt_job.side),
    .out_valid (rat_valid),
    .out_quo   (rat_quo),
    .out_sb    (rat_side)
  );

  // position assembly
  logic                pp_valid;
  logic [POS_N_W-1:0]  pp_n0, pp_n1;
  place_t              pp_place;

  cbf_pos_prep u_pos_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rat_valid),
    .in_q0     (rat_quo[0]),
    .in_q1     (rat_quo[1]),
    .in_side   (rat_side),
    .out_valid (pp_valid),
    .out_n0    (pp_n0),
    .out_n1    (pp_n1),
    .out_place (pp_place)
  );

  // divide by the resolution
  logic [POS_N_W-1:0] pos_num [2];
  logic [RES_W-1:0]   pos_den [2];
  logic [POS_Q_W-1:0] pos_quo [2];
  logic               pos_valid;
  place_t             pos_place;

  assign pos_num[0] = pp_n0;
  assign pos_num[1] = pp_n1;
  assign pos_den[0] = res_eff;
  assign pos_den[1] = res_eff;

  cbf_div_pipe #(
    .LANES (2),
    .DEN_W (RES_W),
    .QUO_W (POS_Q_W),
    .SB_W  ($bits(place_t))
  ) u_pos_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pp_valid),
    .in_num    (pos_num),
    .in_den    (pos_den),
    .in_sb     (pp_place),
    .out_valid (pos_valid),
    .out_quo   (pos_quo),
    .out_sb    (pos_place)
  );

  // round, saturate and sign the positions
  logic [POS_Q_W:0]        hs0, hs1;
  logic [POS_Q_W-1:0]      hm0, hm1, hc0, hc1;
  logic signed [POS_W-1:0] h0, h1;

  assign hs0 = {1'b0, pos_quo[0]} + (POS_Q_W+1)'(1);
  assign hs1 = {1'b0, pos_quo[1]} + (POS_Q_W+1)'(1);
  assign hm0 = hs0[POS_Q_W:1];
  assign hm1 = hs1[POS_Q_W:1];
  assign hc0 = (hm0 > POS_Q_W'(POS_LIM)) ? POS_Q_W'(POS_LIM) : hm0;
  assign hc1 = (hm1 > POS_Q_W'(POS_LIM)) ? POS_Q_W'(POS_LIM) : hm1;
  assign h0  = pos_place.neg0 ? -$signed(POS_W'(hc0)) : $signed(POS_W'(hc0));
  assign h1  = pos_place.neg1 ? -$signed(POS_W'(hc1)) : $signed(POS_W'(hc1));

  // output register
  logic signed [POS_W-1:0] near_r, far_r;
  logic signed [WGT_W-1:0] g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pos_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near_r <= h0;
      far_r  <= h1;
      g_r    <= pos_place.g;
    end
  end

  assign out_chan.valid             = out_valid_r;
  assign out_chan.near_fetch_pos    = near_r;
  assign out_chan.far_fetch_pos     = far_r;
  assign out_chan.first_pair_weight = g_r;

endmodule
